// File: rtl/dvru_pkg.sv
// ----------------------------------------------------------------------------
// dvru_pkg: shared types for the distance-vector route update engine
// Message/result beat layouts, opcodes and config register indexes.
// ----------------------------------------------------------------------------
package dvru_pkg;

  localparam int unsigned NodeW    = 3;
  localparam int unsigned CostW    = 15;
  localparam int unsigned LinkW    = 16;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

  typedef logic [NodeW-1:0] node_t;
  typedef logic [CostW-1:0] cost_t;

  typedef enum logic [1:0] {
    OP_PING   = 2'd0,
    OP_REPLY  = 2'd1,
    OP_VECTOR = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SELF_NODE  = 2'd0,
    CFG_LINK_LOW   = 2'd1,
    CFG_LINK_HIGH  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] operation;
    node_t      source_node;
    node_t      dest_node;
    cost_t      advertised_cost;
  } msg_t;

  typedef struct packed {
    logic  send_reply;
    logic  flood_table;
    logic  route_changed;
    node_t changed_dest;
    node_t changed_next_hop;
    cost_t changed_cost;
  } result_t;

  // write request into the route table
  typedef struct packed {
    logic  en;
    node_t idx;
    cost_t cost;
  } tbl_wr_t;

  // read response from the route table
  typedef struct packed {
    logic  valid;
    cost_t cost;
  } tbl_rd_t;

endpackage

// File: rtl/dvru_route_table.sv
// ----------------------------------------------------------------------------
// dvru_route_table: per-destination route storage
// Valid bits reset to zero; cost is written on install only. The next hop
// of an entry is reported in the result beat and needs no storage here.
// ----------------------------------------------------------------------------
module dvru_route_table #(
  parameter int unsigned NODES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dvru_pkg::node_t  rd_idx_i,
  output dvru_pkg::tbl_rd_t rd_o,
  input  dvru_pkg::tbl_wr_t wr_i
);
  import dvru_pkg::*;

  localparam int unsigned IdxW = (NODES > 1) ? $clog2(NODES) : 1;

  logic [NODES-1:0] valid_q;
  cost_t            cost_q [NODES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx[IdxW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      cost_q[wr_i.idx[IdxW-1:0]] <= wr_i.cost;
    end
  end

  assign rd_o.valid = valid_q[rd_idx_i[IdxW-1:0]];
  assign rd_o.cost  = cost_q[rd_idx_i[IdxW-1:0]];

endmodule

// File: rtl/distance_vector_route_update.sv
// An accepted message beat is held in msg_q, then executed into the result register.
// The accept/execute sequencer takes no new message until the current one executes; it
//   shares one saturating adder and cost comparator over a single table entry.
// The result register frees the execute step as soon as the previous result drains.
// Reset: route valid bits, neighbor connected flags and config registers clear at once;
//   no clearing pass, the block is ready right after reset.
// ----------------------------------------------------------------------------
// distance_vector_route_update: routing table update engine for one node
// Handles ping, ping reply and advertised vector entries; installs routes when
// absent or strictly cheaper (ping/reply on first contact only), flags reply/flood requests.
// ----------------------------------------------------------------------------
module distance_vector_route_update #(
  parameter int unsigned NODES = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [dvru_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dvru_pkg::CfgDataW-1:0]     cfg_data_i,
  // message beats
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  dvru_pkg::msg_t                    in_data_i,
  // result beats
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output dvru_pkg::result_t                 out_data_o
);
  import dvru_pkg::*;

  // one-hot sequencer
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // config registers
  node_t         self_q;
  logic [63:0]   link_lo_q;
  logic [63:0]   link_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q    <= '0;
      link_lo_q <= '0;
      link_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SELF_NODE: self_q    <= cfg_data_i[NodeW-1:0];
        CFG_LINK_LOW:  link_lo_q <= cfg_data_i;
        CFG_LINK_HIGH: link_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured message
  msg_t msg_q;
  logic in_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      msg_q <= in_data_i;
    end
  end

  // result register
  logic    out_valid_q;
  result_t out_q;
  logic    push;

  assign push        = (state_q == ST_EXEC) & (~out_valid_q | out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_EXEC;
      ST_EXEC: if (push)    state_d = ST_IDLE;
      default:              state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------
  // Execute step: one saturating add, one compare, one table entry.
  // ---------------------------------------------------------------------
  op_e            op;
  logic           is_vec;
  logic           ignore;
  node_t          target;
  logic [127:0]   link_all;
  logic [LinkW-1:0] link_raw;
  cost_t          link_sat;
  cost_t          addend;
  logic [CostW:0] sum_raw;
  cost_t          sum_sat;
  tbl_rd_t        tbl_rd;
  tbl_wr_t        tbl_wr;
  logic           better;
  logic [NODES-1:0] conn_q;
  logic           conn_hit;
  result_t        res;

  assign op       = op_e'(msg_q.operation);
  assign is_vec   = (op == OP_VECTOR);
  assign link_all = {link_hi_q, link_lo_q};
  assign link_raw = link_all[{msg_q.source_node, 4'b0000} +: LinkW];
  // link costs above the cost ceiling clamp to it
  assign link_sat = link_raw[LinkW-1] ? CostMax : link_raw[CostW-1:0];
  // ping/reply install the direct route: nothing added to the link cost
  assign addend   = is_vec ? msg_q.advertised_cost : '0;
  assign sum_raw  = {1'b0, addend} + {1'b0, link_sat};
  assign sum_sat  = sum_raw[CostW] ? CostMax : sum_raw[CostW-1:0];
  assign target   = is_vec ? msg_q.dest_node : msg_q.source_node;

  assign ignore = (op == OP_RSVD)
                | ({1'b0, msg_q.source_node} >= (NodeW+1)'(NODES))
                | (is_vec & (({1'b0, msg_q.dest_node} >= (NodeW+1)'(NODES))
                             | (msg_q.dest_node == self_q)));

  // absent, or strictly cheaper than stored
  assign better = ~tbl_rd.valid | (sum_sat < tbl_rd.cost);

  localparam int unsigned IdxW = (NODES > 1) ? $clog2(NODES) : 1;
  assign conn_hit = conn_q[msg_q.source_node[IdxW-1:0]];

  always_comb begin
    res        = '0;
    tbl_wr     = '0;
    tbl_wr.idx = target;
    tbl_wr.cost = sum_sat;
    if (!ignore) begin
      if (is_vec) begin
        if (better) begin
          tbl_wr.en   = 1'b1;
          res.flood_table = 1'b1;
        end
      end else begin
        res.send_reply = (op == OP_PING);
        if (!conn_hit) begin
          // first contact: flood regardless of whether the route improved
          res.flood_table = 1'b1;
          tbl_wr.en       = better;
        end
      end
    end
    if (tbl_wr.en) begin
      res.route_changed    = 1'b1;
      res.changed_dest     = target;
      res.changed_next_hop = msg_q.source_node;
      res.changed_cost     = sum_sat;
    end
    tbl_wr.en = tbl_wr.en & push;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q <= '0;
    end else if (push && !ignore && !is_vec) begin
      conn_q[msg_q.source_node[IdxW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= res;
    end
  end

  dvru_route_table #(
    .NODES (NODES)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (target),
    .rd_o     (tbl_rd),
    .wr_i     (tbl_wr)
  );

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_EXEC)) else $error("accepted beat not executed");

  a_write_with_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_wr.en |-> (push && res.route_changed)) else $error("table write without result");

  a_change_floods: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.route_changed) |-> out_data_o.flood_table)
    else $error("route change without flood");

  a_clean_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.route_changed) |->
      (out_data_o.changed_cost == '0 && out_data_o.changed_dest == '0 &&
       out_data_o.changed_next_hop == '0)) else $error("stale change fields");
`endif

endmodule
